@@ hdl/sbs_pkg.sv @@
// types and constants shared by the sub-pixel bitmap shifter
// item structs, register indexes and the line store control bundle
// no dependencies
package sbs_pkg;

    localparam int PIX_W      = 8;
    localparam int CARRY_W    = 9;
    localparam int SHIFT_W    = 6;
    localparam int FRAC_BITS  = 6;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_H   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_V   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RESET = 13'd1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             start_of_frame;
    } sbs_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_row;
    } sbs_out_t;

    typedef struct packed {
        logic step;   // whole pipeline moves on this edge
        logic rd_en;  // an item in the first stage fetches its top carry
        logic wr_en;  // an item in stage two stores its downward carry
    } sbs_line_ctrl_t;

endpackage

@@ hdl/subpixel_bitmap_shift.sv @@
// top level of the sub-pixel bitmap shifter
// column tracking, configuration registers and the three-stage datapath
// depends on sbs_pkg and sbs_carry_line
//
// usage:
//   input channel in_valid/in_ready/in_item carries one pixel per item in raster
//   order; start_of_frame on the first pixel of a bitmap restarts row and column
//   output channel out_valid/out_ready/out_item gives one item per input item,
//   in order, with end_of_row set on the last pixel of each row
//   configuration is written through cfg_we/cfg_index/cfg_data while idle
// timing:
//   three-stage pipeline: an item passes through stage one, stage two and the
//   output register to out_*; one item per cycle while the output is not stalled
//   the line store has one read and one write port, the read issued in stage
//   one and the write back done in stage two
// reset:
//   row_width 1, both shifts 0, column 0, first row, pipeline empty; the line
//   store is not cleared, the first row of each frame discards what it reads
// stall:
//   while out_valid is high and out_ready low the whole pipeline holds and
//   in_ready is low; a held output register frees as soon as it is taken
module subpixel_bitmap_shift
    import sbs_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sbs_in_t               in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sbs_out_t              out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int WW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    // configuration
    logic [CFG_DATA_W-1:0] row_width_reg;
    logic [SHIFT_W-1:0]    shift_h_reg;
    logic [SHIFT_W-1:0]    shift_v_reg;

    // column tracking
    logic [CW-1:0]         column_count_reg;
    logic [CW-1:0]         column_count_next;
    logic                  first_row_reg;
    logic                  first_row_next;

    logic                  step;
    logic                  accept;
    logic [WW-1:0]         eff_width;
    logic [WW-1:0]         last_col;
    logic [WW-1:0]         rw_ext;
    logic [WW-1:0]         col_base;
    logic [WW-1:0]         col_sel;
    logic [WW-1:0]         col_inc;
    logic                  acc_last;
    logic                  acc_first;

    // stage one
    logic                  s1_valid_reg;
    logic [PIX_W-1:0]      s1_pixel_reg;
    logic [CW-1:0]         s1_col_reg;
    logic                  s1_row_start_reg;
    logic                  s1_first_row_reg;
    logic                  s1_last_reg;
    logic [CARRY_W-1:0]    left_carry_reg;
    logic [CARRY_W-1:0]    s1_px;
    logic [14:0]           prod_h;
    logic [CARRY_W-1:0]    bx;
    logic [CARRY_W:0]      s1_v;

    // stage two
    logic                  s2_valid_reg;
    logic [CARRY_W:0]      s2_v_reg;
    logic [CW-1:0]         s2_col_reg;
    logic                  s2_first_row_reg;
    logic                  s2_last_reg;
    logic [15:0]           prod_v;
    logic [CARRY_W:0]      by;
    logic [CARRY_W-1:0]    by_sat;
    logic [CARRY_W-1:0]    line_rd;
    logic [CARRY_W-1:0]    top;
    logic [CARRY_W+1:0]    s2_sum;
    logic [CARRY_W+1:0]    s2_round;
    logic [PIX_W-1:0]      s2_pixel;

    // output register
    logic                  out_valid_reg;
    sbs_out_t              out_item_reg;

    sbs_line_ctrl_t        line_ctrl;

    assign step     = !out_valid_reg || out_ready;
    assign in_ready = step;
    assign accept   = in_valid && step;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            shift_h_reg   <= '0;
            shift_v_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_WIDTH: row_width_reg <= cfg_data;
                CFG_SHIFT_H:   shift_h_reg   <= cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_V:   shift_v_reg   <= cfg_data[SHIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    // effective row width, zero taken as one and clamped to the line store
    always_comb
    begin
        rw_ext = WW'(row_width_reg);
        if (rw_ext == '0)
        begin
            eff_width = WW'(1);
        end
        else if (rw_ext > WW'(MAX_ROW_WIDTH))
        begin
            eff_width = WW'(MAX_ROW_WIDTH);
        end
        else
        begin
            eff_width = rw_ext;
        end
        last_col = eff_width - WW'(1);

        col_base  = in_item.start_of_frame ? '0 : WW'(column_count_reg);
        acc_first = in_item.start_of_frame || first_row_reg;
        // a column beyond a narrowed row sticks at the last column
        col_sel   = (col_base >= eff_width) ? last_col : col_base;
        acc_last  = (col_sel == last_col);
        col_inc   = col_sel + WW'(1);

        column_count_next = column_count_reg;
        first_row_next    = first_row_reg;
        if (accept)
        begin
            if (acc_last)
            begin
                column_count_next = '0;
                first_row_next    = 1'b0;
            end
            else
            begin
                column_count_next = col_inc[CW-1:0];
                first_row_next    = acc_first;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            first_row_reg    <= 1'b1;
        end
        else
        begin
            column_count_reg <= column_count_next;
            first_row_reg    <= first_row_next;
        end
    end

    // stage one: horizontal part out, left neighbour's part in
    always_comb
    begin
        s1_px  = {s1_pixel_reg, 1'b0};
        prod_h = {6'b0, s1_px} * {9'b0, shift_h_reg};
        bx     = prod_h[14:FRAC_BITS];
        s1_v   = {1'b0, s1_px} - {1'b0, bx}
               + (s1_row_start_reg ? '0 : {1'b0, left_carry_reg});
    end

    // stage two: vertical part out, part from the row above in
    always_comb
    begin
        prod_v   = {6'b0, s2_v_reg} * {10'b0, shift_v_reg};
        by       = prod_v[15:FRAC_BITS];
        by_sat   = by[CARRY_W] ? {CARRY_W{1'b1}} : by[CARRY_W-1:0];
        top      = s2_first_row_reg ? '0 : line_rd;
        s2_sum   = {1'b0, s2_v_reg} - {1'b0, by} + {2'b0, top};
        s2_round = s2_sum + (CARRY_W+2)'(1);
        s2_pixel = (s2_round[CARRY_W+1:1] > (CARRY_W+1)'(255))
                 ? {PIX_W{1'b1}} : s2_round[PIX_W:1];
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_carry_reg <= '0;
        end
        else if (step)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                left_carry_reg <= bx;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (accept)
            begin
                s1_pixel_reg     <= in_item.pixel_in;
                s1_col_reg       <= col_sel[CW-1:0];
                s1_row_start_reg <= (col_sel == '0);
                s1_first_row_reg <= acc_first;
                s1_last_reg      <= acc_last;
            end
            if (s1_valid_reg)
            begin
                s2_v_reg         <= s1_v;
                s2_col_reg       <= s1_col_reg;
                s2_first_row_reg <= s1_first_row_reg;
                s2_last_reg      <= s1_last_reg;
            end
            if (s2_valid_reg)
            begin
                out_item_reg.pixel_out  <= s2_pixel;
                out_item_reg.end_of_row <= s2_last_reg;
            end
        end
    end

    assign line_ctrl.step  = step;
    assign line_ctrl.rd_en = s1_valid_reg;
    assign line_ctrl.wr_en = s2_valid_reg;

    sbs_carry_line #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_carry_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (line_ctrl),
        .rd_addr (s1_col_reg),
        .wr_addr (s2_col_reg),
        .wr_data (by_sat),
        .rd_data (line_rd)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && acc_last) |=> (column_count_reg == '0) && !first_row_reg)
        else $error("column count did not wrap at end of row");
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.start_of_frame) |=> s1_valid_reg && s1_first_row_reg
            && s1_row_start_reg)
        else $error("frame start not marked as first row and row start");
    a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("output item appeared without a stage two item");
    a_column_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (WW'(s1_col_reg) < WW'(MAX_ROW_WIDTH)))
        else $error("column beyond line store");
`endif

endmodule

@@ hdl/sbs_carry_line.sv @@
// line store of downward carries, one 9-bit entry per column
// registered synchronous read, same-edge write forwarding
// depends on sbs_pkg
module sbs_carry_line
    import sbs_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sbs_line_ctrl_t                       ctrl,
    input  logic [$clog2(MAX_ROW_WIDTH)-1:0]     rd_addr,
    input  logic [$clog2(MAX_ROW_WIDTH)-1:0]     wr_addr,
    input  logic [CARRY_W-1:0]                   wr_data,
    output logic [CARRY_W-1:0]                   rd_data
);

    logic [CARRY_W-1:0] line_mem [MAX_ROW_WIDTH];
    logic [CARRY_W-1:0] rd_q_reg;
    logic [CARRY_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic               fwd_hit_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.step && ctrl.wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (ctrl.step && ctrl.rd_en)
        begin
            rd_q_reg <= line_mem[rd_addr];
        end
        if (ctrl.step)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // read and write of one column on the same edge: the memory read is stale, so the written data is forwarded
    always_comb
    begin
        fwd_hit_next = fwd_hit_reg;
        if (ctrl.step)
        begin
            fwd_hit_next = ctrl.rd_en && ctrl.wr_en && (rd_addr == wr_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

`ifndef SYNTHESIS
    a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_hit_reg) |-> $past(ctrl.step && ctrl.wr_en && ctrl.rd_en))
        else $error("forward flagged without a colliding write");
    a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && ctrl.rd_en && ctrl.wr_en && rd_addr != wr_addr) |=> !fwd_hit_reg)
        else $error("forward flagged for different columns");
    a_fwd_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.step |=> $stable(fwd_hit_reg))
        else $error("forward flag changed while the pipeline held");
`endif

endmodule

@@ sim/sbs_shift_checker.sv @@
`timescale 1ns / 1ps
// prediction and comparison for the sub-pixel bitmap shifter
// watches the pixel, result and register ports and hands a failure count and a pending count to the top
// depends on sbs_pkg
module sbs_shift_checker
    import sbs_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  sbs_in_t               in_item,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  sbs_out_t              out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    localparam int CARRY_MAX  = (1 << CARRY_W) - 1;
    localparam int PIX_MAX    = (1 << PIX_W) - 1;
    localparam int REPORT_MAX = 10;

    logic [CFG_DATA_W-1:0] row_width;
    logic [SHIFT_W-1:0]    shift_h;
    logic [SHIFT_W-1:0]    shift_v;
    int                    column;
    logic                  first_row;
    logic [CARRY_W-1:0]    left_part;
    logic [CARRY_W-1:0]    down_line [MAX_ROW_WIDTH];

    sbs_out_t expected_pixels [$];
    sbs_out_t want;
    int       error_count;
    int       result_index;

    // advances the column state by one item and returns the shifted pixel
    function automatic sbs_out_t shift_pixel(input sbs_in_t item);
        int       w;
        int       col;
        int       left;
        int       top;
        int       px;
        int       bx;
        int       by;
        int       res;
        sbs_out_t r;
        w = int'(row_width);
        if (w == 0)
            w = 1;
        if (w > MAX_ROW_WIDTH)
            w = MAX_ROW_WIDTH;
        if (item.start_of_frame)
        begin
            column    = 0;
            first_row = 1'b1;
            left_part = '0;
        end
        // a width lowered mid-row pins the column to the new last one
        col  = (column >= w) ? w - 1 : column;
        left = (col == 0) ? 0 : int'(left_part);
        top  = first_row ? 0 : int'(down_line[col]);

        px  = int'(item.pixel_in) * 2;
        bx  = (px * int'(shift_h)) >> FRAC_BITS;
        px  = px - bx + left;
        by  = (px * int'(shift_v)) >> FRAC_BITS;
        px  = px - by + top;
        res = (px + 1) >> 1;
        if (res > PIX_MAX)
            res = PIX_MAX;

        // carries only overflow when shifts change mid-frame
        left_part      = (bx > CARRY_MAX) ? CARRY_W'(CARRY_MAX) : CARRY_W'(bx);
        down_line[col] = (by > CARRY_MAX) ? CARRY_W'(CARRY_MAX) : CARRY_W'(by);

        r.pixel_out  = PIX_W'(res);
        r.end_of_row = (col == w - 1);
        if (r.end_of_row)
        begin
            column    = 0;
            first_row = 1'b0;
        end
        else
            column = col + 1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width    = ROW_WIDTH_RESET;
            shift_h      = '0;
            shift_v      = '0;
            column       = 0;
            first_row    = 1'b1;
            left_part    = '0;
            error_count  = 0;
            result_index = 0;
            expected_pixels.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_WIDTH: row_width = cfg_data;
                    CFG_SHIFT_H:   shift_h   = cfg_data[SHIFT_W-1:0];
                    CFG_SHIFT_V:   shift_v   = cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                expected_pixels.push_back(shift_pixel(in_item));

            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("result %0d: unexpected item, pixel_out %0d end_of_row %0b",
                                 result_index, out_item.pixel_out, out_item.end_of_row);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_item.pixel_out !== want.pixel_out ||
                        out_item.end_of_row !== want.end_of_row)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("result %0d: pixel_out exp %0d got %0d, end_of_row exp %0b got %0b",
                                     result_index, want.pixel_out, out_item.pixel_out,
                                     want.end_of_row, out_item.end_of_row);
                    end
                end
                result_index++;
            end

            mismatches <= error_count;
            pending    <= expected_pixels.size();
        end
    end

endmodule

@@ sim/tb_subpixel_bitmap_shift.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the sub-pixel bitmap shifter
// drives pixels, registers and output stalls; checking sits in sbs_shift_checker
// depends on sbs_pkg, subpixel_bitmap_shift and sbs_shift_checker
module tb_subpixel_bitmap_shift
    import sbs_pkg::*;
();

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_ROW_WIDTH  = 4096;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;

    // index that maps to no register, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    sbs_in_t               in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sbs_out_t              out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROW_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_count    = 0;
    int quiet_cycles  = 0;

    subpixel_bitmap_shift #(
        .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sbs_shift_checker #(
        .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver: random stalls, plus one long hold-off to back the pipeline up
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_subpixel_bitmap_shift: errors");
            $finish;
        end
    end

    // upper bits are random so that the register is seen to keep only its own width
    function automatic logic [CFG_DATA_W-1:0] shift_word(input int s);
        return {7'($urandom), 6'(s)};
    endfunction

    function automatic int pick_shift();
        case ($urandom_range(3))
            0:       return 0;
            1:       return (1 << SHIFT_W) - 1;
            default: return $urandom_range((1 << SHIFT_W) - 1);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic program_regs(input logic [CFG_DATA_W-1:0] width_word,
                                input logic [CFG_DATA_W-1:0] sh_word,
                                input logic [CFG_DATA_W-1:0] sv_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_WIDTH;
        cfg_data  <= width_word;
        @(posedge clk);
        cfg_index <= CFG_SHIFT_H;
        cfg_data  <= sh_word;
        @(posedge clk);
        cfg_index <= CFG_SHIFT_V;
        cfg_data  <= sv_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{pixel_in: pix, start_of_frame: sof};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] width_word;
        int                    width;
        int                    prev_width;
        int                    items;
        int                    sof_pct;
        bit                    fresh;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no shift: every pixel passes through unchanged
        program_regs(13'd4, shift_word(0), shift_word(0));
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_INDEX;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd128, 1'b0);
        drain_pipeline();

        // largest shifts on full coverage, two rows so the line store is read
        program_regs(13'd3, shift_word(63), shift_word(63));
        send_pixel(8'd255, 1'b1);
        repeat (5) send_pixel(8'd255, 1'b0);
        drain_pipeline();

        // zero width behaves as one pixel per row
        program_regs(13'd0, shift_word(32), shift_word(17));
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd255, 1'b0);
        drain_pipeline();

        // width lowered mid-row: the next pixel closes the row
        program_regs(13'd8, shift_word(40), shift_word(20));
        send_pixel(8'd90, 1'b1);
        repeat (5) send_pixel(rand_pixel(), 1'b0);
        drain_pipeline();
        program_regs(13'd3, shift_word(40), shift_word(20));
        repeat (3) send_pixel(rand_pixel(), 1'b0);
        drain_pipeline();

        // horizontal shift dropped mid-frame leaves an oversized left carry
        program_regs(13'd2, shift_word(63), shift_word(63));
        send_pixel(8'd255, 1'b1);
        repeat (2) send_pixel(8'd255, 1'b0);
        drain_pipeline();
        program_regs(13'd2, shift_word(0), shift_word(63));
        repeat (3) send_pixel(8'd255, 1'b0);
        drain_pipeline();

        prev_width = 2;
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 85;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 85;
                end
                default:
                begin
                    send_idle_pct = 6;
                    stall_pct     = 6;
                end
            endcase
            if (ph == 0)
                hold_req = 1'b1;

            // one phase with the width clamped to the line store, the rest kept narrow
            if (ph == 5)
            begin
                width_word = '1;
                items      = 85;
                sof_pct    = 0;
            end
            else
            begin
                width_word = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(13, 64))
                                                      : CFG_DATA_W'($urandom_range(1, 12));
                items      = 85;
                sof_pct    = 3;
            end
            width = (width_word > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(width_word);

            // carrying on in the same frame is only safe when the row does not grow
            fresh      = (width > prev_width) || ($urandom_range(1) == 0);
            prev_width = width;

            program_regs(width_word, shift_word(pick_shift()), shift_word(pick_shift()));
            for (int i = 0; i < items; i++)
                send_pixel(rand_pixel(), (i == 0 && fresh) || ($urandom_range(99) < sof_pct));
            drain_pipeline();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_subpixel_bitmap_shift: clean");
        else
            $display("tb_subpixel_bitmap_shift: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sbs_pkg.sv
hdl/sbs_carry_line.sv
hdl/subpixel_bitmap_shift.sv
sim/sbs_shift_checker.sv
sim/tb_subpixel_bitmap_shift.sv
